// ===== hw/rtl/crc24cs_pkg.sv =====
`default_nettype none

package crc24cs_pkg;

   localparam int CrcWidth = 24;
   localparam int ByteWidth = 8;
   localparam int CsrIndexWidth = 3;
   localparam int QueueDepthDefault = 2;

   localparam logic [CrcWidth-1:0] PolynomialReset = 24'h864CFB;
   localparam logic [CrcWidth-1:0] FinalXorReset = 24'h000000;

   // register indexes on the csr port
   localparam logic [CsrIndexWidth-1:0] CsrPolynomial = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CsrFinalXor = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CsrReflectIn = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CsrReflectOut = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CsrContinuation = 3'd4;

   typedef struct packed {
      logic [CrcWidth-1:0] polynomial;
      logic [CrcWidth-1:0] final_xor;
      logic                reflect_in;
      logic                reflect_out;
      logic                continuation_mode;
   } cfg_type;

   // one classified transaction as it waits between front and back
   typedef struct packed {
      logic [CrcWidth-1:0]  start_value;
      logic [ByteWidth-1:0] data_byte;
      logic                 has_byte;
      logic                 is_first;
      logic                 is_last;
   } item_type;

   function automatic logic [ByteWidth-1:0] rev8(input logic [ByteWidth-1:0] v);
      logic [ByteWidth-1:0] r;
      for (int i = 0; i < ByteWidth; i++) begin
         r[i] = v[ByteWidth-1-i];
      end
      return r;
   endfunction

   function automatic logic [CrcWidth-1:0] rev24(input logic [CrcWidth-1:0] v);
      logic [CrcWidth-1:0] r;
      for (int i = 0; i < CrcWidth; i++) begin
         r[i] = v[CrcWidth-1-i];
      end
      return r;
   endfunction

   // eight MSB-first division steps over one byte
   function automatic logic [CrcWidth-1:0] clock_byte(input logic [CrcWidth-1:0]  crc,
                                                      input logic [ByteWidth-1:0] data,
                                                      input logic [CrcWidth-1:0]  poly);
      logic [CrcWidth-1:0] c;
      c = crc ^ {data, {(CrcWidth-ByteWidth){1'b0}}};
      for (int i = 0; i < ByteWidth; i++) begin
         if (c[CrcWidth-1]) begin
            c = {c[CrcWidth-2:0], 1'b0} ^ poly;
         end else begin
            c = {c[CrcWidth-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/crc24cs_front.sv =====
`default_nettype none

module crc24cs_front
   import crc24cs_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cfg_type              cfg,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [ByteWidth-1:0] req_data_byte,
   input  wire logic                 req_has_byte,
   input  wire logic                 req_is_first,
   input  wire logic                 req_is_last,
   input  wire logic [CrcWidth-1:0]  req_start_value,
   input  wire logic                 queue_full,
   output logic                      push,
   output item_type                  push_item
);

   always_comb begin
      req_stall = queue_full;
      push = req_valid && !queue_full;
      // apply input-side reflections now so the back only divides and folds the output
      push_item.start_value = (cfg.reflect_out && cfg.continuation_mode) ?
                              rev24(req_start_value) : req_start_value;
      push_item.data_byte = cfg.reflect_in ? rev8(req_data_byte) : req_data_byte;
      push_item.has_byte = req_has_byte;
      push_item.is_first = req_is_first;
      push_item.is_last = req_is_last;
   end

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && queue_full) |-> !push)
      else $error("front pushed into a full queue");

endmodule

`default_nettype wire

// ===== hw/rtl/crc24cs_queue.sv =====
`default_nettype none

module crc24cs_queue
   import crc24cs_pkg::*;
#(
   parameter int QUEUE_DEPTH = QueueDepthDefault
)
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   output logic          full,
   output logic          pop_valid,
   output item_type      pop_item,
   input  wire logic     pop
);

   localparam int IdxWidth = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntWidth = $clog2(QUEUE_DEPTH + 1);
   localparam logic [IdxWidth-1:0] LastIdx = IdxWidth'(QUEUE_DEPTH - 1);
   localparam logic [CntWidth-1:0] FullCount = CntWidth'(QUEUE_DEPTH);

   item_type            slot_ff [QUEUE_DEPTH];
   logic [IdxWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IdxWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;

   always_comb begin
      full = (count_ff == FullCount);
      pop_valid = (count_ff != '0);
      pop_item = slot_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastIdx) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastIdx) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= FullCount)
      else $error("queue count beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("pop from an empty queue");

endmodule

`default_nettype wire

// ===== hw/rtl/crc24cs_back.sv =====
`default_nettype none

module crc24cs_back
   import crc24cs_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cfg_type             cfg,
   input  wire logic                item_valid,
   input  wire item_type            item,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [CrcWidth-1:0]      rsp_crc_value
);

   logic [CrcWidth-1:0] crc_ff, crc_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CrcWidth-1:0] rsp_crc_ff, rsp_crc_in;
   logic [CrcWidth-1:0] base;
   logic [CrcWidth-1:0] folded;

   always_comb begin
      // take the next transaction only when the output register frees up
      pop = item_valid && (!rsp_valid_ff || !rsp_stall);
      base = item.is_first ? item.start_value : crc_ff;
      crc_in = crc_ff;
      if (pop) begin
         crc_in = item.has_byte ? clock_byte(base, item.data_byte, cfg.polynomial) : base;
      end
      folded = (cfg.reflect_out ? rev24(crc_in) : crc_in) ^ cfg.final_xor;
      rsp_valid_in = rsp_valid_ff;
      rsp_crc_in = rsp_crc_ff;
      if (pop) begin
         rsp_valid_in = item.is_last;
         if (item.is_last) begin
            rsp_crc_in = folded;
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         crc_ff <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_crc_ff <= rsp_crc_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_crc_value = rsp_crc_ff;

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pop && item.is_last))
      else $error("result raised without a last transaction");

   assert property (@(posedge clock) disable iff (reset)
      !pop |=> crc_ff == $past(crc_ff))
      else $error("crc register moved without a transaction");

endmodule

`default_nettype wire

// ===== hw/rtl/crc24_configurable_stream.sv =====
`default_nettype none

// 24-bit CRC over a byte stream, MSB-first, configurable polynomial.
// Request channel (req_*): one transaction per cycle carries an optional byte,
// first/last markers and the start value used with the first marker.
// Response channel (rsp_*): one CRC per transaction marked last.
// Both channels move a transaction when valid is high and stall is low.
// CSR port: write polynomial, final xor and the three flag registers by
// index while no message is in flight; writes take effect on later traffic.
// Path: an accepted transaction waits in the queue, then the back end pops it
// and registers its result. Throughput: one transaction per cycle unless a
// held result blocks it, with the eight-step byte update done combinationally.
// A small queue separates request intake from the CRC engine; when rsp_stall
// holds the result register, the queue fills and req_stall rises once full.
// Reset (synchronous) restores the default registers, clears the CRC
// register to zero and empties the queue and the result register.
module crc24_configurable_stream
   import crc24cs_pkg::*;
#(
   parameter int QUEUE_DEPTH = QueueDepthDefault
)
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [ByteWidth-1:0]     req_data_byte,
   input  wire logic                     req_has_byte,
   input  wire logic                     req_is_first,
   input  wire logic                     req_is_last,
   input  wire logic [CrcWidth-1:0]      req_start_value,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [CrcWidth-1:0]           rsp_crc_value,
   input  wire logic                     csr_write_enable,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CrcWidth-1:0]      csr_write_data
);

   cfg_type  cfg_ff, cfg_in;
   logic     push;
   item_type push_item;
   logic     queue_full;
   logic     pop_valid;
   item_type pop_item;
   logic     pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CsrPolynomial:   cfg_in.polynomial = csr_write_data;
            CsrFinalXor:     cfg_in.final_xor = csr_write_data;
            CsrReflectIn:    cfg_in.reflect_in = csr_write_data[0];
            CsrReflectOut:   cfg_in.reflect_out = csr_write_data[0];
            CsrContinuation: cfg_in.continuation_mode = csr_write_data[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.polynomial <= PolynomialReset;
         cfg_ff.final_xor <= FinalXorReset;
         cfg_ff.reflect_in <= 1'b0;
         cfg_ff.reflect_out <= 1'b0;
         cfg_ff.continuation_mode <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   crc24cs_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_has_byte    (req_has_byte),
      .req_is_first    (req_is_first),
      .req_is_last     (req_is_last),
      .req_start_value (req_start_value),
      .queue_full      (queue_full),
      .push            (push),
      .push_item       (push_item)
   );

   crc24cs_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop_valid (pop_valid),
      .pop_item  (pop_item),
      .pop       (pop)
   );

   crc24cs_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .item_valid    (pop_valid),
      .item          (pop_item),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_crc_value (rsp_crc_value)
   );

endmodule

`default_nettype wire

// ===== tb/tb_crc24_configurable_stream.sv =====
module tb_crc24_configurable_stream;
   import crc24cs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CsrIndexWidth-1:0] CsrFirstUnused = CsrContinuation + 1'b1;
   localparam logic [CrcWidth-1:0] CrcAllOnes = {CrcWidth{1'b1}};

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [ByteWidth-1:0]     req_data_byte = '0;
   logic                     req_has_byte = 1'b0;
   logic                     req_is_first = 1'b0;
   logic                     req_is_last = 1'b0;
   logic [CrcWidth-1:0]      req_start_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [CrcWidth-1:0]      rsp_crc_value;
   logic                     csr_write_enable = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CrcWidth-1:0]      csr_write_data = '0;

   crc24_configurable_stream uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_has_byte     (req_has_byte),
      .req_is_first     (req_is_first),
      .req_is_last      (req_is_last),
      .req_start_value  (req_start_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_crc_value    (rsp_crc_value),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   // shadow of the block's registers and running CRC
   logic [CrcWidth-1:0] cfg_poly = PolynomialReset;
   logic [CrcWidth-1:0] cfg_final_xor = FinalXorReset;
   logic                cfg_reflect_in = 1'b0;
   logic                cfg_reflect_out = 1'b0;
   logic                cfg_continuation = 1'b0;
   logic [CrcWidth-1:0] crc_model = '0;

   item_type            pending_items[$];
   logic [CrcWidth-1:0] expected_crcs[$];
   item_type            offered_item;

   int  error_count = 0;
   int  items_accepted = 0;
   int  results_checked = 0;
   int  settings_used = 0;
   int  send_gap = 0;
   int  recv_hold = 0;
   int  long_hold_request = 0;
   bit  idle_on = 1'b1;

   function automatic logic [CrcWidth-1:0] swap24(input logic [CrcWidth-1:0] v);
      logic [CrcWidth-1:0] r;
      foreach (v[i]) r[CrcWidth-1-i] = v[i];
      return r;
   endfunction

   function automatic logic [ByteWidth-1:0] swap8(input logic [ByteWidth-1:0] v);
      logic [ByteWidth-1:0] r;
      foreach (v[i]) r[ByteWidth-1-i] = v[i];
      return r;
   endfunction

   function automatic logic [CrcWidth-1:0] divide_byte(input logic [CrcWidth-1:0] crc,
                                                       input logic [ByteWidth-1:0] b);
      logic [CrcWidth-1:0] c;
      c = crc ^ (CrcWidth'(b) << (CrcWidth - ByteWidth));
      repeat (ByteWidth) begin
         c = c[CrcWidth-1] ? ((c << 1) ^ cfg_poly) : (c << 1);
      end
      return c;
   endfunction

   task automatic advance_crc_model(input item_type it);
      logic [CrcWidth-1:0] folded;
      if (it.is_first) begin
         crc_model = (cfg_reflect_out && cfg_continuation) ? swap24(it.start_value)
                                                            : it.start_value;
      end
      if (it.has_byte) begin
         crc_model = divide_byte(crc_model, cfg_reflect_in ? swap8(it.data_byte)
                                                           : it.data_byte);
      end
      if (it.is_last) begin
         folded = cfg_reflect_out ? swap24(crc_model) : crc_model;
         expected_crcs.push_back(folded ^ cfg_final_xor);
      end
   endtask

   task automatic note_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("MISMATCH: %s", msg);
   endtask

   // driver: hold the payload while stalled, pick the next transaction otherwise
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            advance_crc_model(offered_item);
            items_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(0, 4);
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               offered_item = pending_items.pop_front();
               req_valid <= 1'b1;
               req_data_byte <= offered_item.data_byte;
               req_has_byte <= offered_item.has_byte;
               req_is_first <= offered_item.is_first;
               req_is_last <= offered_item.is_last;
               req_start_value <= offered_item.start_value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each CRC against the oldest prediction, drive rsp_stall
   always @(posedge clock) begin
      logic [CrcWidth-1:0] want;
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_crcs.size() == 0) begin
               note_error($sformatf("unexpected crc_value %06h", rsp_crc_value));
            end else begin
               want = expected_crcs.pop_front();
               if (rsp_crc_value !== want)
                  note_error($sformatf("crc_value expected %06h got %06h",
                                       want, rsp_crc_value));
               else
                  results_checked++;
            end
         end
         if (long_hold_request > 0) begin
            recv_hold = long_hold_request;
            long_hold_request = 0;
         end
         if (recv_hold > 0) begin
            recv_hold--;
            rsp_stall <= 1'b1;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            recv_hold = $urandom_range(0, 4);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic write_csr(input logic [CsrIndexWidth-1:0] idx,
                            input logic [CrcWidth-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      case (idx)
         CsrPolynomial:   cfg_poly = value;
         CsrFinalXor:     cfg_final_xor = value;
         CsrReflectIn:    cfg_reflect_in = value[0];
         CsrReflectOut:   cfg_reflect_out = value[0];
         CsrContinuation: cfg_continuation = value[0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // flags take bit 0 only; scramble the rest of the word
   task automatic set_config(input logic [CrcWidth-1:0] poly, input logic [CrcWidth-1:0] fx,
                             input bit rin, input bit rout, input bit cont);
      logic [CrcWidth-1:0] word;
      write_csr(CsrPolynomial, poly);
      write_csr(CsrFinalXor, fx);
      word = CrcWidth'($urandom());
      word[0] = rin;
      write_csr(CsrReflectIn, word);
      word = CrcWidth'($urandom());
      word[0] = rout;
      write_csr(CsrReflectOut, word);
      word = CrcWidth'($urandom());
      word[0] = cont;
      write_csr(CsrContinuation, word);
      if ($urandom_range(0, 2) == 0)
         write_csr(CsrFirstUnused + CsrIndexWidth'($urandom_range(0, 2)),
                   CrcWidth'($urandom()));
      settings_used++;
   endtask

   task automatic queue_item(input logic [ByteWidth-1:0] b, input bit has, input bit first,
                             input bit last, input logic [CrcWidth-1:0] sv);
      item_type it;
      it.data_byte = b;
      it.has_byte = has;
      it.is_first = first;
      it.is_last = last;
      it.start_value = sv;
      pending_items.push_back(it);
   endtask

   function automatic logic [CrcWidth-1:0] pick_start();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return CrcAllOnes;
         default: return CrcWidth'($urandom());
      endcase
   endfunction

   // mostly well-formed messages, some broken ones, some lone noise items
   task automatic queue_random(input int target);
      int added;
      int len;
      int kind;
      bit first;
      bit last;
      added = 0;
      while (added < target) begin
         kind = $urandom_range(0, 9);
         if (kind == 9) begin
            queue_item(ByteWidth'($urandom()), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_start());
            added++;
         end else begin
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
               first = (k == 0);
               last = (k == len - 1);
               // break the framing: drop a marker or restart mid-message
               if (kind == 7 && $urandom_range(0, 1) == 0) first = 1'b0;
               if (kind == 7 && last && $urandom_range(0, 1) == 0) last = 1'b0;
               if (kind == 8 && $urandom_range(0, 3) == 0) first = 1'b1;
               queue_item(ByteWidth'($urandom()), $urandom_range(0, 9) != 0, first, last,
                          pick_start());
            end
            added += len;
         end
      end
   endtask

   task automatic wait_idle();
      while (pending_items.size() != 0 || req_valid || expected_crcs.size() != 0)
         @(negedge clock);
      // let non-final transactions still inside the block drain
      repeat (8) @(negedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part on reset settings
      queue_item(8'h5A, 1'b1, 1'b0, 1'b1, 24'h123456);
      queue_item(8'hFF, 1'b0, 1'b1, 1'b1, CrcAllOnes);
      queue_item(8'hFF, 1'b1, 1'b1, 1'b1, 24'h000000);
      queue_item(8'h80, 1'b1, 1'b1, 1'b1, 24'h800000);
      queue_item(8'h00, 1'b1, 1'b1, 1'b1, CrcAllOnes);
      queue_item(8'h11, 1'b1, 1'b1, 1'b0, 24'h5A5A5A);
      queue_item(8'h22, 1'b0, 1'b0, 1'b0, CrcAllOnes);
      queue_item(8'h33, 1'b1, 1'b0, 1'b1, 24'h000000);
      for (int k = 0; k < 9; k++)
         queue_item(8'h31 + ByteWidth'(k), 1'b1, k == 0, k == 8, 24'hB704CE);
      queue_item(8'hA5, 1'b1, 1'b0, 1'b0, 24'h000000);
      queue_item(8'h00, 1'b0, 1'b0, 1'b1, CrcAllOnes);
      queue_item(8'hC3, 1'b1, 1'b1, 1'b0, 24'hABCDEF);
      queue_item(8'h3C, 1'b1, 1'b1, 1'b1, 24'h000001);
      queue_item(8'hFF, 1'b0, 1'b0, 1'b0, 24'h654321);
      queue_item(8'h01, 1'b1, 1'b0, 1'b1, 24'h000000);
      wait_idle();

      idle_on = 1'b0;
      set_config('0, CrcAllOnes, 1'b0, 1'b0, 1'b0);
      @(negedge clock);
      queue_random(50);
      wait_idle();

      // long receiver hold while the sender keeps offering
      idle_on = 1'b1;
      set_config(CrcAllOnes, '0, 1'b1, 1'b1, 1'b1);
      @(negedge clock);
      long_hold_request = 80;
      queue_random(50);
      wait_idle();

      set_config(PolynomialReset, CrcWidth'($urandom()), 1'b0, 1'b1, 1'b0);
      @(negedge clock);
      queue_random(50);
      wait_idle();

      set_config(CrcWidth'($urandom()), CrcWidth'($urandom()), 1'b1, 1'b0, 1'b1);
      @(negedge clock);
      queue_random(50);
      wait_idle();

      repeat (3) begin
         set_config(CrcWidth'($urandom()), CrcWidth'($urandom()), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         @(negedge clock);
         queue_random(50);
         wait_idle();
      end

      // final stretch without idling
      idle_on = 1'b0;
      set_config(CrcWidth'($urandom()), CrcWidth'($urandom()), 1'b1, 1'b1, 1'b1);
      @(negedge clock);
      queue_random(50);
      wait_idle();

      if (expected_crcs.size() != 0) note_error("predicted CRCs never arrived");
      $display("Run covered %0d transactions and %0d checked CRCs over %0d register settings",
               items_accepted, results_checked, settings_used + 1);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #200000;
      $display("Timeout with %0d CRCs outstanding", expected_crcs.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule
